// ===== rtl/core/ntt_pkg.sv =====
package ntt_pkg;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 56;
    localparam int BYTE_ADDR_W = 19;
    localparam int SIZE_W      = 11;

    localparam logic [CFG_INDEX_W-1:0] REG_MEMORY_SIZE  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ID_LENGTH    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SUPPLIED_UID = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_READ_ONLY    = 2'd3;

    localparam logic [SIZE_W-1:0] MEMORY_SIZE_RESET = 11'd1024;

    localparam logic [1:0] CMD_FRAME = 2'd0;
    localparam logic [1:0] CMD_INIT  = 2'd1;
    localparam logic [1:0] CMD_LOAD  = 2'd2;

    localparam logic [7:0] OP_READ   = 8'h30;
    localparam logic [7:0] OP_WRITE  = 8'hA2;
    localparam logic [7:0] OP_SECSEL = 8'hC2;
    localparam logic [7:0] OP_HALT   = 8'h50;
    localparam logic [7:0] REPLY_ACK = 8'h0A;
    localparam logic [7:0] REPLY_NAK = 8'h00;

    localparam logic [7:0] CASCADE_TAG   = 8'h88;
    localparam logic [7:0] CC_MAGIC      = 8'hE1;
    localparam logic [7:0] CC_VERSION    = 8'h10;
    localparam logic [7:0] CC_NO_WRITE   = 8'h0F;
    localparam logic [7:0] CC_OPEN       = 8'h00;
    localparam logic [7:0] TLV_NDEF      = 8'h03;
    localparam logic [7:0] TLV_TERM      = 8'hFE;
    localparam logic [3:0] UID_LEN_FULL  = 4'd7;
    localparam logic [3:0] UID_LEN_DFLT  = 4'd0;
    localparam logic [55:0] DEFAULT_UID  = 56'h04_11_22_33_44_55_66;
    localparam logic [SIZE_W-1:0] MIN_SIZE = 11'd20;
    localparam logic [SIZE_W-1:0] HEADER_BYTES = 11'd16;

    typedef struct packed {
        logic [7:0]  reply_room;
        logic [31:0] payload_word;
        logic [7:0]  second_byte;
        logic [7:0]  first_byte;
        logic [5:0]  frame_length;
    } in_item_t;

    typedef struct packed {
        logic        init_ok;
        logic [9:0]  changed_address;
        logic        memory_changed;
        logic [2:0]  reply_bytes;
        logic [31:0] reply_data;
    } out_item_t;

    typedef enum logic [1:0] {
        ACT_NONE,
        ACT_REPLY,
        ACT_READ,
        ACT_INIT
    } act_t;

    typedef enum logic [1:0] {
        OUT_DEC,
        OUT_READ,
        OUT_INIT
    } out_sel_t;

    typedef struct packed {
        logic     capture;
        logic     commit;
        logic     clr_wr;
        logic     init_wr;
        logic     rd_issue;
        logic     step_clr;
        logic     step_inc;
        logic     out_load;
        out_sel_t out_sel;
    } ctrl_cmd_t;

    typedef struct packed {
        act_t act;
        logic clr_done;
        logic step_rd_last;
        logic step_init_last;
        logic out_free;
    } ctrl_sts_t;

endpackage

// ===== rtl/core/ntt_datapath.sv =====
module ntt_datapath
    import ntt_pkg::*;
#(
    parameter int MEM_BYTES = 1024
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic [1:0]             in_command,
    input  in_item_t               in_item,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  ctrl_cmd_t              cmd,
    output ctrl_sts_t              sts,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output out_item_t              m_item,
    output logic                   m_tlast
);

    localparam int MEM_WORDS = (MEM_BYTES + 3) / 4;
    localparam int AW        = $clog2(MEM_WORDS);

    logic [SIZE_W-1:0]  mem_size_reg;
    logic [3:0]         id_length_reg;
    logic [55:0]        uid_reg;
    logic               read_only_reg;

    logic [1:0]         command_reg;
    in_item_t           item_reg;
    logic [7:0]         sector_reg;
    logic               pend_reg;
    logic [2:0]         step_reg;
    logic [AW-1:0]      clr_cnt_reg;
    logic [31:0]        rd_data_reg;
    logic               m_valid_reg;
    logic               m_last_reg;
    out_item_t          m_item_reg;

    logic [31:0]        mem_words [MEM_WORDS];

    logic [SIZE_W-1:0]      size_use;
    logic [BYTE_ADDR_W-1:0] size_ext;
    logic [15:0]            blk_word;
    logic [BYTE_ADDR_W-1:0] blk_addr;
    logic [BYTE_ADDR_W-1:0] sel_base;
    logic [15:0]            host_word;
    logic [BYTE_ADDR_W-1:0] host_end;
    logic                   init_ok;

    act_t                   dec_act;
    out_item_t              dec_out;
    logic                   dec_mem_we;
    logic [15:0]            dec_mem_word;
    logic                   dec_pend;
    logic [7:0]             dec_sector;

    logic [16:0]            rd_word;
    logic [BYTE_ADDR_W-1:0] rd_base;
    logic [31:0]            rd_masked;

    logic [55:0]            uid_sel;
    logic [7:0]             u0, u1, u2, u3, u4, u5, u6;
    logic [7:0]             cc_units;
    logic [SIZE_W-1:0]      size_less_hdr;
    logic [31:0]            init_word;

    logic                   mem_we;
    logic [AW-1:0]          mem_addr;
    logic [31:0]            mem_wdata;
    logic [3:0]             mem_be;

    out_item_t              out_next;
    logic                   last_next;

    assign size_use = ({8'b0, mem_size_reg} < BYTE_ADDR_W'(MEM_BYTES))
                      ? mem_size_reg : SIZE_W'(MEM_BYTES);
    assign size_ext = {8'b0, size_use};

    assign blk_word  = {sector_reg, item_reg.second_byte};
    assign blk_addr  = {1'b0, blk_word, 2'b00};
    assign sel_base  = {1'b0, item_reg.first_byte, 10'b0};
    assign host_word = {item_reg.first_byte, item_reg.second_byte};
    assign host_end  = {1'b0, host_word, 2'b00} + BYTE_ADDR_W'(4);
    assign init_ok   = (size_use >= MIN_SIZE) &&
                       ((id_length_reg == UID_LEN_DFLT) || (id_length_reg == UID_LEN_FULL));

    always_comb begin
        dec_act      = ACT_NONE;
        dec_out      = '0;
        dec_mem_we   = 1'b0;
        dec_mem_word = blk_word;
        dec_pend     = pend_reg;
        dec_sector   = sector_reg;
        case (command_reg)
            CMD_FRAME: begin
                if (item_reg.frame_length != 6'd0) begin
                    if (pend_reg) begin
                        dec_pend = 1'b0;
                        if (item_reg.frame_length >= 6'd4) begin
                            if (sel_base >= size_ext) begin
                                if (item_reg.reply_room != 8'd0) begin
                                    dec_act = ACT_REPLY;
                                    dec_out.reply_data  = {24'b0, REPLY_NAK};
                                    dec_out.reply_bytes = 3'd1;
                                end
                            end else begin
                                dec_sector = item_reg.first_byte;
                            end
                        end
                    end else begin
                        case (item_reg.first_byte)
                            OP_READ: begin
                                if (item_reg.frame_length >= 6'd2 &&
                                    item_reg.reply_room >= 8'd16) begin
                                    if (blk_addr >= size_ext) begin
                                        dec_act = ACT_REPLY;
                                        dec_out.reply_data  = {24'b0, REPLY_NAK};
                                        dec_out.reply_bytes = 3'd1;
                                    end else begin
                                        dec_act = ACT_READ;
                                    end
                                end
                            end
                            OP_WRITE: begin
                                if (item_reg.frame_length >= 6'd6 &&
                                    item_reg.reply_room != 8'd0) begin
                                    dec_act = ACT_REPLY;
                                    dec_out.reply_bytes = 3'd1;
                                    if (blk_word < 16'd4 || read_only_reg ||
                                        (blk_addr + BYTE_ADDR_W'(4)) > size_ext) begin
                                        dec_out.reply_data = {24'b0, REPLY_NAK};
                                    end else begin
                                        dec_mem_we = 1'b1;
                                        dec_out.reply_data      = {24'b0, REPLY_ACK};
                                        dec_out.memory_changed  = 1'b1;
                                        dec_out.changed_address = blk_addr[9:0];
                                    end
                                end
                            end
                            OP_SECSEL: begin
                                if (item_reg.reply_room != 8'd0) begin
                                    dec_act = ACT_REPLY;
                                    dec_out.reply_bytes = 3'd1;
                                    if (item_reg.frame_length >= 6'd2 &&
                                        item_reg.second_byte == 8'hFF) begin
                                        dec_pend = 1'b1;
                                        dec_out.reply_data = {24'b0, REPLY_ACK};
                                    end else begin
                                        dec_out.reply_data = {24'b0, REPLY_NAK};
                                    end
                                end
                            end
                            OP_HALT: begin
                                dec_act = ACT_NONE;
                            end
                            default: begin
                                if (item_reg.reply_room != 8'd0) begin
                                    dec_act = ACT_REPLY;
                                    dec_out.reply_data  = {24'b0, REPLY_NAK};
                                    dec_out.reply_bytes = 3'd1;
                                end
                            end
                        endcase
                    end
                end
            end
            CMD_INIT: begin
                if (init_ok) begin
                    dec_act    = ACT_INIT;
                    dec_pend   = 1'b0;
                    dec_sector = 8'd0;
                end else begin
                    dec_act = ACT_REPLY;
                end
            end
            CMD_LOAD: begin
                dec_mem_word = host_word;
                dec_mem_we   = (host_end <= size_ext);
            end
            default: begin
                dec_act = ACT_NONE;
            end
        endcase
    end

    assign uid_sel = (id_length_reg == UID_LEN_FULL) ? uid_reg : DEFAULT_UID;
    assign u0 = uid_sel[55:48];
    assign u1 = uid_sel[47:40];
    assign u2 = uid_sel[39:32];
    assign u3 = uid_sel[31:24];
    assign u4 = uid_sel[23:16];
    assign u5 = uid_sel[15:8];
    assign u6 = uid_sel[7:0];
    assign size_less_hdr = size_use - HEADER_BYTES;
    assign cc_units = size_less_hdr[10:3];

    always_comb begin
        case (step_reg)
            3'd0:    init_word = {CASCADE_TAG ^ u0 ^ u1 ^ u2, u2, u1, u0};
            3'd1:    init_word = {u6, u5, u4, u3};
            3'd2:    init_word = {24'b0, u3 ^ u4 ^ u5 ^ u6};
            3'd3:    init_word = {read_only_reg ? CC_NO_WRITE : CC_OPEN, cc_units,
                                  CC_VERSION, CC_MAGIC};
            default: init_word = {8'h00, TLV_TERM, 8'h00, TLV_NDEF};
        endcase
    end

    always_comb begin
        mem_we    = 1'b0;
        mem_addr  = dec_mem_word[AW-1:0];
        mem_wdata = item_reg.payload_word;
        mem_be    = 4'hF;
        if (cmd.clr_wr) begin
            mem_we    = 1'b1;
            mem_addr  = clr_cnt_reg;
            mem_wdata = 32'b0;
        end else if (cmd.init_wr) begin
            mem_we    = 1'b1;
            mem_addr  = AW'(step_reg);
            mem_wdata = init_word;
            mem_be    = sts.step_init_last ? 4'h7 : 4'hF;
        end else if (cmd.commit) begin
            mem_we = dec_mem_we;
        end
    end

    assign rd_word = {1'b0, blk_word} + 17'(step_reg);
    assign rd_base = {rd_word, 2'b00};

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            rd_masked[8*i +: 8] = ((rd_base + BYTE_ADDR_W'(i)) < size_ext)
                                  ? rd_data_reg[8*i +: 8] : 8'h00;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            for (int i = 0; i < 4; i++) begin
                if (mem_be[i]) begin
                    mem_words[mem_addr][8*i +: 8] <= mem_wdata[8*i +: 8];
                end
            end
        end
        if (cmd.rd_issue) begin
            rd_data_reg <= mem_words[rd_word[AW-1:0]];
        end
    end

    always_comb begin
        out_next  = '0;
        last_next = 1'b1;
        case (cmd.out_sel)
            OUT_DEC: begin
                out_next = dec_out;
            end
            OUT_READ: begin
                out_next.reply_data  = rd_masked;
                out_next.reply_bytes = 3'd4;
                last_next            = sts.step_rd_last;
            end
            OUT_INIT: begin
                out_next.init_ok = 1'b1;
            end
            default: begin
                out_next = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            command_reg <= in_command;
            item_reg    <= in_item;
        end
        if (cmd.out_load) begin
            m_item_reg <= out_next;
            m_last_reg <= last_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mem_size_reg  <= MEMORY_SIZE_RESET;
            id_length_reg <= 4'd0;
            uid_reg       <= 56'd0;
            read_only_reg <= 1'b0;
            sector_reg    <= 8'd0;
            pend_reg      <= 1'b0;
            step_reg      <= 3'd0;
            clr_cnt_reg   <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_MEMORY_SIZE:  mem_size_reg  <= cfg_wdata[SIZE_W-1:0];
                    REG_ID_LENGTH:    id_length_reg <= cfg_wdata[3:0];
                    REG_SUPPLIED_UID: uid_reg       <= cfg_wdata[55:0];
                    REG_READ_ONLY:    read_only_reg <= cfg_wdata[0];
                    default:          read_only_reg <= read_only_reg;
                endcase
            end
            if (cmd.commit) begin
                sector_reg <= dec_sector;
                pend_reg   <= dec_pend;
            end
            if (cmd.step_clr) begin
                step_reg <= 3'd0;
            end else if (cmd.step_inc) begin
                step_reg <= step_reg + 3'd1;
            end
            if (cmd.clr_wr) begin
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign sts.act            = dec_act;
    assign sts.clr_done       = (clr_cnt_reg == AW'(MEM_WORDS - 1));
    assign sts.step_rd_last   = (step_reg == 3'd3);
    assign sts.step_init_last = (step_reg == 3'd4);
    assign sts.out_free       = !m_valid_reg || m_tready;

    assign m_tvalid = m_valid_reg;
    assign m_item   = m_item_reg;
    assign m_tlast  = m_last_reg;

endmodule

// ===== rtl/core/ntt_ctrl.sv =====
module ntt_ctrl
    import ntt_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  ctrl_sts_t sts,
    output ctrl_cmd_t cmd
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_RD_REQ,
        ST_RD_OUT,
        ST_INIT_WR,
        ST_INIT_OUT
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.out_sel = OUT_DEC;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clr_wr = 1'b1;
                if (sts.clr_done) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                cmd.capture = s_tvalid;
                if (s_tvalid) begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                case (sts.act)
                    ACT_NONE: begin
                        cmd.commit = 1'b1;
                        state_next = ST_IDLE;
                    end
                    ACT_REPLY: begin
                        if (sts.out_free) begin
                            cmd.commit   = 1'b1;
                            cmd.out_load = 1'b1;
                            state_next   = ST_IDLE;
                        end
                    end
                    ACT_READ: begin
                        cmd.commit   = 1'b1;
                        cmd.step_clr = 1'b1;
                        state_next   = ST_RD_REQ;
                    end
                    ACT_INIT: begin
                        cmd.commit   = 1'b1;
                        cmd.step_clr = 1'b1;
                        state_next   = ST_INIT_WR;
                    end
                    default: begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_RD_REQ: begin
                cmd.rd_issue = 1'b1;
                state_next   = ST_RD_OUT;
            end
            ST_RD_OUT: begin
                cmd.out_sel = OUT_READ;
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.step_inc = 1'b1;
                    state_next   = sts.step_rd_last ? ST_IDLE : ST_RD_REQ;
                end
            end
            ST_INIT_WR: begin
                cmd.init_wr  = 1'b1;
                cmd.step_inc = 1'b1;
                if (sts.step_init_last) begin
                    state_next = ST_INIT_OUT;
                end
            end
            ST_INIT_OUT: begin
                cmd.out_sel = OUT_INIT;
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

    a_no_result_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> sts.out_free)
        else $error("result register loaded while a result is still waiting");

    a_one_mem_user: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.clr_wr, cmd.init_wr, cmd.commit, cmd.rd_issue}))
        else $error("memory port claimed by more than one operation");

    a_read_step_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RD_REQ || state_reg == ST_RD_OUT) |-> !sts.step_init_last)
        else $error("read burst stepped past its fourth word");

    a_clear_before_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(!aresetn) |-> !s_tready)
        else $error("input accepted before the memory clear finished");

endmodule

// ===== rtl/core/nfc_type2_tag_responder.sv =====
// Tag side of the NFC Type 2 block protocol, working on a memory of 4-byte blocks.
// The input stream carries one received frame, header init request or host block
// load per beat; tuser selects which. Each item gives zero to four result beats on
// the output stream, with tlast on the final beat of an item.
// Configuration registers are written through cfg_we, cfg_index and cfg_wdata
// while the block is idle; the user keeps to this, as the block does not enforce
// it; a write lands at the clock edge where cfg_we is high. After reset the block
// runs a clearing pass over all (MEM_BYTES+3)/4 memory words (256 at the default
// size), one word per cycle, and takes no input beats until it ends. All work
// shares a single memory port; a read does one memory read and one output beat
// per word. A single-byte reply goes from the decode state into the output
// register; a read word passes through the read data register and then the
// output register, and an init status follows the header writes.
// Results sit in an output register; a new input beat is taken while a result
// waits there. When the receiver stalls, the block holds the next result in its
// working state until the output register frees up.
module nfc_type2_tag_responder
    import ntt_pkg::*;
#(
    parameter int MEM_BYTES = 1024
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // frame_length, first_byte, second_byte, payload_word, reply_room, zero pad
    input  logic [63:0]            s_tdata,
    // command
    input  logic [1:0]             s_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // reply_data, reply_bytes, memory_changed, changed_address, init_ok, zero pad
    output logic [47:0]            m_tdata,
    output logic                   m_tlast,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

    ctrl_cmd_t cmd;
    ctrl_sts_t sts;
    in_item_t  in_item;
    out_item_t m_item;

    assign in_item = in_item_t'(s_tdata[61:0]);
    assign m_tdata = {1'b0, m_item};

    ntt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ntt_datapath #(
        .MEM_BYTES (MEM_BYTES)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_command (s_tuser),
        .in_item    (in_item),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .cmd        (cmd),
        .sts        (sts),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_item     (m_item),
        .m_tlast    (m_tlast)
    );

endmodule
